// File: design/tensor_constant_pad_scatter_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tensor constant pad scatter unit
// Concurrent checks written once here; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef TENSOR_CONSTANT_PAD_SCATTER_UNIT_ASSERT_SVH
`define TENSOR_CONSTANT_PAD_SCATTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TCPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tcps: same-cycle check failed");
// next-cycle implication
`define TCPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tcps: next-cycle check failed");
`else
`define TCPS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TCPS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: design/tcps_pkg.sv
// ----------------------------------------------------------------------------
// tcps_pkg
// Shared constants, register indexes and types of the constant pad scatter unit.
// ----------------------------------------------------------------------------
package tcps_pkg;

	// fixed field widths
	localparam int FIELD_W    = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int EXT_W      = 11;
	localparam int PAD_W      = 8;
	localparam int OEXT_W     = 12;   // extent + two pad bytes
	localparam int TOT_W      = 48;   // exact product of four padded extents
	localparam int NUM_DIMS   = 4;

	// parameter defaults
	localparam int DEF_ELEM_BITS  = 32;
	localparam int DEF_MAX_EXTENT = 1024;
	localparam int DEF_INDEX_BITS = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IN_BATCHES  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_BEFORE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_AFTER   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_VALUE   = 3'd6;

	// request function codes
	localparam logic FUNC_FILL = 1'b0;
	localparam logic FUNC_DATA = 1'b1;

	// register file contents; dimension 0 is the batch, 3 the column
	typedef struct packed {
		logic [NUM_DIMS-1:0][EXT_W-1:0] ext;
		logic [CFG_DATA_W-1:0]          pad_before;
		logic [CFG_DATA_W-1:0]          pad_after;
		logic [CFG_DATA_W-1:0]          pad_value;
	} cfg_t;

	// status of the derived-value sequencer
	typedef struct packed {
		logic ready;
		logic load;
	} prep_stat_t;

endpackage

// File: design/tcps_ifs.sv
// ----------------------------------------------------------------------------
// tcps channel interfaces
// Valid/ready channels for input requests, result writes and register writes.
// ----------------------------------------------------------------------------
interface tcps_item_if
	import tcps_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               func;
	logic [FIELD_W-1:0] elem_value;

	modport source (output valid, func, elem_value, input ready);
	modport sink (input valid, func, elem_value, output ready);
endinterface

interface tcps_result_if
	import tcps_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] out_index;
	logic [FIELD_W-1:0] out_value;
	logic               phase_last;

	modport source (output valid, out_index, out_value, phase_last, input ready);
	modport sink (input valid, out_index, out_value, phase_last, output ready);
endinterface

interface tcps_cfg_if
	import tcps_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: design/tcps_cfg_regs.sv
// ----------------------------------------------------------------------------
// tcps_cfg_regs
// Configuration register file: extents, packed pad counts and pad value.
// ----------------------------------------------------------------------------
module tcps_cfg_regs
	import tcps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_idx,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < NUM_DIMS; d++) begin
				cfg_q.ext[d] <= EXT_W'(1);
			end
			cfg_q.pad_before <= '0;
			cfg_q.pad_after  <= '0;
			cfg_q.pad_value  <= '0;
		end else if (wr_en) begin
			unique case (wr_idx)
				REG_IN_BATCHES:  cfg_q.ext[0]    <= wr_data[EXT_W-1:0];
				REG_IN_CHANNELS: cfg_q.ext[1]    <= wr_data[EXT_W-1:0];
				REG_IN_HEIGHT:   cfg_q.ext[2]    <= wr_data[EXT_W-1:0];
				REG_IN_WIDTH:    cfg_q.ext[3]    <= wr_data[EXT_W-1:0];
				REG_PAD_BEFORE:  cfg_q.pad_before <= wr_data;
				REG_PAD_AFTER:   cfg_q.pad_after  <= wr_data;
				REG_PAD_VALUE:   cfg_q.pad_value  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: design/tcps_prep.sv
// ----------------------------------------------------------------------------
// tcps_prep
// Derived-value sequencer: clamped and padded extents, strides, saturated
// total, per-dimension index terms; all products go through one shared multiplier.
// ----------------------------------------------------------------------------
module tcps_prep
	import tcps_pkg::*;
#(
	parameter int MAX_EXTENT = DEF_MAX_EXTENT,
	parameter int INDEX_BITS = DEF_INDEX_BITS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    restart,
	input  cfg_t                                    cfg,
	input  logic [NUM_DIMS-1:0][$clog2(MAX_EXTENT)-1:0] cnt,
	output logic [NUM_DIMS-1:0][EXT_W-1:0]          cext,
	output logic [NUM_DIMS-1:0][INDEX_BITS-1:0]     stride,
	output logic [NUM_DIMS-1:0][INDEX_BITS-1:0]     base,
	output logic [NUM_DIMS-1:0][INDEX_BITS-1:0]     cinit,
	output logic [INDEX_BITS:0]                     total,
	output prep_stat_t                              stat
);

	localparam int CNT_W  = $clog2(MAX_EXTENT);
	localparam int OPB_W  = ((CNT_W > PAD_W) ? CNT_W : PAD_W) + 1;
	localparam int MB_W   = (OPB_W > OEXT_W) ? OPB_W : OEXT_W;
	localparam int PROD_W = TOT_W + MB_W;
	localparam logic [PROD_W-1:0] TOT_CAP = PROD_W'(1) << INDEX_BITS;
	localparam logic [31:0] MAX_EXT_W32 = 32'(MAX_EXTENT);

	localparam logic [3:0] STEP_EXT  = 4'd0;
	localparam logic [3:0] STEP_ST1  = 4'd1;
	localparam logic [3:0] STEP_ST0  = 4'd2;
	localparam logic [3:0] STEP_TOT  = 4'd3;
	localparam logic [3:0] STEP_C2   = 4'd4;
	localparam logic [3:0] STEP_B2   = 4'd5;
	localparam logic [3:0] STEP_C1   = 4'd6;
	localparam logic [3:0] STEP_B1   = 4'd7;
	localparam logic [3:0] STEP_C0   = 4'd8;
	localparam logic [3:0] STEP_B0   = 4'd9;
	localparam logic [3:0] STEP_LOAD = 4'd10;
	localparam logic [3:0] STEP_IDLE = 4'd11;

	logic [3:0]                          step_q;
	logic [3:0]                          step_nxt;
	logic [NUM_DIMS-1:0][EXT_W-1:0]      ce_q;
	logic [NUM_DIMS-1:0][OEXT_W-1:0]     oe_q;
	logic [TOT_W-1:0]                    st1_q;
	logic [TOT_W-1:0]                    st0_q;
	logic [INDEX_BITS:0]                 tot_q;
	logic [NUM_DIMS-1:0][INDEX_BITS-1:0] cin_q;
	logic [NUM_DIMS-1:0][INDEX_BITS-1:0] base_q;

	logic [NUM_DIMS-1:0][PAD_W-1:0]      pb;
	logic [NUM_DIMS-1:0][PAD_W-1:0]      pa;
	logic [NUM_DIMS-1:0][EXT_W-1:0]      ce;
	logic [NUM_DIMS-1:0][OPB_W-1:0]      opb;
	logic [TOT_W-1:0]                    mul_a;
	logic [MB_W-1:0]                     mul_b;
	logic [PROD_W-1:0]                   prod;

	// pad bytes, clamped extents and counter-plus-pad operands
	always_comb begin
		for (int d = 0; d < NUM_DIMS; d++) begin
			pb[d] = cfg.pad_before[PAD_W*(NUM_DIMS-1-d) +: PAD_W];
			pa[d] = cfg.pad_after[PAD_W*(NUM_DIMS-1-d) +: PAD_W];
			if (cfg.ext[d] == '0) begin
				ce[d] = EXT_W'(1);
			end else if (32'(cfg.ext[d]) > MAX_EXT_W32) begin
				ce[d] = EXT_W'(MAX_EXTENT);
			end else begin
				ce[d] = cfg.ext[d];
			end
			opb[d] = OPB_W'(cnt[d]) + OPB_W'(pb[d]);
		end
	end

	// shared multiplier operand select
	always_comb begin
		unique case (step_q)
			STEP_ST1: begin mul_a = TOT_W'(oe_q[3]); mul_b = MB_W'(oe_q[2]); end
			STEP_ST0: begin mul_a = st1_q;           mul_b = MB_W'(oe_q[1]); end
			STEP_TOT: begin mul_a = st0_q;           mul_b = MB_W'(oe_q[0]); end
			STEP_C2:  begin mul_a = TOT_W'(oe_q[3]); mul_b = MB_W'(opb[2]);  end
			STEP_B2:  begin mul_a = TOT_W'(oe_q[3]); mul_b = MB_W'(pb[2]);   end
			STEP_C1:  begin mul_a = st1_q;           mul_b = MB_W'(opb[1]);  end
			STEP_B1:  begin mul_a = st1_q;           mul_b = MB_W'(pb[1]);   end
			STEP_C0:  begin mul_a = st0_q;           mul_b = MB_W'(opb[0]);  end
			STEP_B0:  begin mul_a = st0_q;           mul_b = MB_W'(pb[0]);   end
			default:  begin mul_a = '0;              mul_b = '0;             end
		endcase
	end

	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	always_comb begin
		unique case (step_q)
			STEP_EXT:  step_nxt = STEP_ST1;
			STEP_ST1:  step_nxt = STEP_ST0;
			STEP_ST0:  step_nxt = STEP_TOT;
			STEP_TOT:  step_nxt = STEP_C2;
			STEP_C2:   step_nxt = STEP_B2;
			STEP_B2:   step_nxt = STEP_C1;
			STEP_C1:   step_nxt = STEP_B1;
			STEP_B1:   step_nxt = STEP_C0;
			STEP_C0:   step_nxt = STEP_B0;
			STEP_B0:   step_nxt = STEP_LOAD;
			STEP_LOAD: step_nxt = STEP_IDLE;
			STEP_IDLE: step_nxt = STEP_IDLE;
			default:   step_nxt = STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_EXT;
		end else if (restart) begin
			step_q <= STEP_EXT;
		end else begin
			step_q <= step_nxt;
		end
	end

	always_ff @(posedge clk) begin
		unique case (step_q)
			STEP_EXT: begin
				for (int d = 0; d < NUM_DIMS; d++) begin
					ce_q[d] <= ce[d];
					oe_q[d] <= OEXT_W'(ce[d]) + OEXT_W'(pb[d]) + OEXT_W'(pa[d]);
				end
			end
			STEP_ST1: begin
				st1_q     <= TOT_W'(prod);
				cin_q[3]  <= INDEX_BITS'(opb[3]);
				base_q[3] <= INDEX_BITS'(pb[3]);
			end
			STEP_ST0: st0_q <= TOT_W'(prod);
			STEP_TOT: begin
				// saturate the output total at the index space
				if (prod > TOT_CAP) begin
					tot_q <= (INDEX_BITS+1)'(TOT_CAP);
				end else begin
					tot_q <= (INDEX_BITS+1)'(prod);
				end
			end
			STEP_C2: cin_q[2]  <= INDEX_BITS'(prod);
			STEP_B2: base_q[2] <= INDEX_BITS'(prod);
			STEP_C1: cin_q[1]  <= INDEX_BITS'(prod);
			STEP_B1: base_q[1] <= INDEX_BITS'(prod);
			STEP_C0: cin_q[0]  <= INDEX_BITS'(prod);
			STEP_B0: base_q[0] <= INDEX_BITS'(prod);
			default: ;
		endcase
	end

	assign cext      = ce_q;
	assign stride[0] = INDEX_BITS'(st0_q);
	assign stride[1] = INDEX_BITS'(st1_q);
	assign stride[2] = INDEX_BITS'(oe_q[3]);
	assign stride[3] = INDEX_BITS'(1);
	assign base      = base_q;
	assign cinit     = cin_q;
	assign total     = tot_q;
	assign stat.ready = (step_q == STEP_IDLE);
	assign stat.load  = (step_q == STEP_LOAD);

endmodule

// File: design/tcps_core.sv
// ----------------------------------------------------------------------------
// tcps_core
// Per-request logic: fill counter, input coordinate counters and the
// per-dimension index terms whose sum is the padded output index.
// ----------------------------------------------------------------------------
module tcps_core
	import tcps_pkg::*;
#(
	parameter int ELEM_BITS  = DEF_ELEM_BITS,
	parameter int MAX_EXTENT = DEF_MAX_EXTENT,
	parameter int INDEX_BITS = DEF_INDEX_BITS
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        accept,
	input  logic                                        func,
	input  logic [FIELD_W-1:0]                          elem_value,
	input  logic [CFG_DATA_W-1:0]                       pad_value,
	input  logic [NUM_DIMS-1:0][EXT_W-1:0]              cext,
	input  logic [NUM_DIMS-1:0][INDEX_BITS-1:0]         stride,
	input  logic [NUM_DIMS-1:0][INDEX_BITS-1:0]         base,
	input  logic [NUM_DIMS-1:0][INDEX_BITS-1:0]         cinit,
	input  logic [INDEX_BITS:0]                         total,
	input  logic                                        load,
	output logic [NUM_DIMS-1:0][$clog2(MAX_EXTENT)-1:0] cnt,
	output logic                                        push,
	output logic [((INDEX_BITS < 32) ? INDEX_BITS : 32)-1:0] push_idx,
	output logic [((ELEM_BITS < 32) ? ELEM_BITS : 32)-1:0]   push_val,
	output logic                                        push_last
);

	localparam int CNT_W  = $clog2(MAX_EXTENT);
	localparam int CMP_W  = ((CNT_W > EXT_W) ? CNT_W : EXT_W) + 1;
	localparam int OIDX_W = (INDEX_BITS < 32) ? INDEX_BITS : 32;
	localparam int VAL_W  = (ELEM_BITS < 32) ? ELEM_BITS : 32;

	logic [INDEX_BITS:0]                 fill_q;
	logic [NUM_DIMS-1:0][CNT_W-1:0]      cnt_q;
	logic [NUM_DIMS-1:0][INDEX_BITS-1:0] c_q;
	logic                                done_q;

	logic [INDEX_BITS:0]     fill_inc;
	logic                    fill_ok;
	logic                    data_go;
	logic [NUM_DIMS-1:0]     at_end;
	logic [NUM_DIMS-1:0]     adv;
	logic                    all_end;
	logic [INDEX_BITS-1:0]   data_idx;

	assign fill_inc = fill_q + (INDEX_BITS+1)'(1);
	assign fill_ok  = (fill_q < total);
	assign data_go  = accept && (func == FUNC_DATA) && !done_q;
	assign data_idx = c_q[0] + c_q[1] + c_q[2] + c_q[3];

	// a counter at or past its last position counts as at its end
	always_comb begin
		for (int d = 0; d < NUM_DIMS; d++) begin
			at_end[d] = (CMP_W'(cnt_q[d]) + CMP_W'(1)) >= CMP_W'(cext[d]);
		end
		adv[NUM_DIMS-1] = 1'b1;
		for (int d = NUM_DIMS-2; d >= 0; d--) begin
			adv[d] = adv[d+1] & at_end[d+1];
		end
	end

	assign all_end = &at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (accept) begin
			if (func == FUNC_FILL) begin
				if (fill_ok) begin
					fill_q <= fill_inc;
				end
			end else if (!done_q) begin
				for (int d = 0; d < NUM_DIMS; d++) begin
					if (adv[d]) begin
						cnt_q[d] <= at_end[d] ? '0 : cnt_q[d] + CNT_W'(1);
					end
				end
				done_q <= all_end;
			end
		end
	end

	// index terms: load the initial terms, step by the stride, or drop back to the leading-pad base
	always_ff @(posedge clk) begin
		if (load) begin
			c_q <= cinit;
		end else if (data_go) begin
			for (int d = 0; d < NUM_DIMS; d++) begin
				if (adv[d]) begin
					c_q[d] <= at_end[d] ? base[d] : c_q[d] + stride[d];
				end
			end
		end
	end

	always_comb begin
		if (func == FUNC_FILL) begin
			push      = accept && fill_ok;
			push_idx  = OIDX_W'(fill_q);
			push_val  = VAL_W'(pad_value);
			push_last = (fill_inc == total);
		end else begin
			push      = data_go;
			push_idx  = OIDX_W'(data_idx);
			push_val  = VAL_W'(elem_value);
			push_last = all_end;
		end
	end

	assign cnt = cnt_q;

endmodule

// File: design/tcps_outbuf.sv
// ----------------------------------------------------------------------------
// tcps_outbuf
// Two-entry result queue that decouples the result channel from the input.
// ----------------------------------------------------------------------------
module tcps_outbuf
	import tcps_pkg::*;
#(
	parameter int IDX_W = DEF_INDEX_BITS,
	parameter int VAL_W = DEF_ELEM_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [IDX_W-1:0] push_idx,
	input  logic [VAL_W-1:0] push_val,
	input  logic             push_last,
	input  logic             pop,
	output logic             valid,
	output logic             space,
	output logic [IDX_W-1:0] out_idx,
	output logic [VAL_W-1:0] out_val,
	output logic             out_last
);

	logic [IDX_W-1:0] idx_q  [2];
	logic [VAL_W-1:0] val_q  [2];
	logic             last_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			idx_q[wr_ptr_q]  <= push_idx;
			val_q[wr_ptr_q]  <= push_val;
			last_q[wr_ptr_q] <= push_last;
		end
	end

	assign valid    = (count_q != 2'd0);
	assign space    = (count_q != 2'd2);
	assign out_idx  = idx_q[rd_ptr_q];
	assign out_val  = val_q[rd_ptr_q];
	assign out_last = last_q[rd_ptr_q];

endmodule

// File: design/tensor_constant_pad_scatter_unit.sv
// ----------------------------------------------------------------------------
// tensor_constant_pad_scatter_unit
// Constant-pad write generator for a rank-4 tensor.
// ----------------------------------------------------------------------------
// Takes one request per clock when not held off and returns its write, if any,
// registered through a two-entry result queue, so a stalled result channel
// costs no rate until the queue is full. A fill request writes the pad value at
// the next linear output index until the padded total is covered; a data
// request writes the element at its padded row-major index, kept as four
// per-dimension terms that step by stride and are summed. After reset and after
// every register write the derived-value sequencer builds the padded extents,
// then strides, saturated total and index terms on its one shared multiplier,
// and holds requests off; register writes are taken in every cycle.

`include "tensor_constant_pad_scatter_unit_assert.svh"

module tensor_constant_pad_scatter_unit
	import tcps_pkg::*;
#(
	parameter int ELEM_BITS  = DEF_ELEM_BITS,
	parameter int MAX_EXTENT = DEF_MAX_EXTENT,
	parameter int INDEX_BITS = DEF_INDEX_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	tcps_item_if.sink     item,
	tcps_result_if.source result,
	tcps_cfg_if.sink      cfg
);

	localparam int CNT_W  = $clog2(MAX_EXTENT);
	localparam int OIDX_W = (INDEX_BITS < 32) ? INDEX_BITS : 32;
	localparam int VAL_W  = (ELEM_BITS < 32) ? ELEM_BITS : 32;

	cfg_t                                cfg_w;
	prep_stat_t                          prep_stat;
	logic [NUM_DIMS-1:0][EXT_W-1:0]      cext;
	logic [NUM_DIMS-1:0][INDEX_BITS-1:0] stride;
	logic [NUM_DIMS-1:0][INDEX_BITS-1:0] base;
	logic [NUM_DIMS-1:0][INDEX_BITS-1:0] cinit;
	logic [INDEX_BITS:0]                 total;
	logic [NUM_DIMS-1:0][CNT_W-1:0]      cnt;
	logic                                cfg_wr;
	logic                                accept;
	logic                                push;
	logic [OIDX_W-1:0]                   push_idx;
	logic [VAL_W-1:0]                    push_val;
	logic                                push_last;
	logic                                buf_space;
	logic [OIDX_W-1:0]                   res_idx;
	logic [VAL_W-1:0]                    res_val;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	// hold requests while derived values are rebuilt, a write is pending or the queue is full
	assign item.ready = prep_stat.ready && !cfg.valid && buf_space;
	assign accept     = item.valid && item.ready;

	tcps_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_wr),
		.wr_idx  (cfg.index),
		.wr_data (cfg.data),
		.cfg     (cfg_w)
	);

	tcps_prep #(
		.MAX_EXTENT (MAX_EXTENT),
		.INDEX_BITS (INDEX_BITS)
	) u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (cfg_wr),
		.cfg     (cfg_w),
		.cnt     (cnt),
		.cext    (cext),
		.stride  (stride),
		.base    (base),
		.cinit   (cinit),
		.total   (total),
		.stat    (prep_stat)
	);

	tcps_core #(
		.ELEM_BITS  (ELEM_BITS),
		.MAX_EXTENT (MAX_EXTENT),
		.INDEX_BITS (INDEX_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.func       (item.func),
		.elem_value (item.elem_value),
		.pad_value  (cfg_w.pad_value),
		.cext       (cext),
		.stride     (stride),
		.base       (base),
		.cinit      (cinit),
		.total      (total),
		.load       (prep_stat.load),
		.cnt        (cnt),
		.push       (push),
		.push_idx   (push_idx),
		.push_val   (push_val),
		.push_last  (push_last)
	);

	tcps_outbuf #(
		.IDX_W (OIDX_W),
		.VAL_W (VAL_W)
	) u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_idx  (push_idx),
		.push_val  (push_val),
		.push_last (push_last),
		.pop       (result.valid && result.ready),
		.valid     (result.valid),
		.space     (buf_space),
		.out_idx   (res_idx),
		.out_val   (res_val),
		.out_last  (result.phase_last)
	);

	assign result.out_index = FIELD_W'(res_idx);
	assign result.out_value = FIELD_W'(res_val);

	`TCPS_ASSERT_IMP(a_push_needs_accept, clk, arst_n, push, item.valid && item.ready)
	`TCPS_ASSERT_IMP(a_ready_after_load, clk, arst_n, $rose(prep_stat.ready), $past(prep_stat.load))
	`TCPS_ASSERT_NXT(a_cfg_restarts_prep, clk, arst_n, cfg.valid && cfg.ready, !prep_stat.ready)
	`TCPS_ASSERT_NXT(a_no_phantom_result, clk, arst_n, !result.valid && !push, !result.valid)

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the constant pad scatter unit against a cycle-free model of its fill
// and data write streams, across reshaped tensors, with random stalls.
// ----------------------------------------------------------------------------
module testbench;
	import tcps_pkg::*;

	localparam int QUIET_LIMIT = 4000;

	typedef struct packed {
		logic [FIELD_W-1:0] index;
		logic [FIELD_W-1:0] value;
		logic               last;
	} pad_write_t;

	logic clk;
	logic arst_n;

	tcps_item_if   item_ch();
	tcps_result_if result_ch();
	tcps_cfg_if    cfg_ch();

	tensor_constant_pad_scatter_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// model state: register copy, fill position, input coordinates
	cfg_t              shape;
	longint unsigned   fill_pos;
	int unsigned       coord [NUM_DIMS];
	bit                data_finished;
	pad_write_t        pending_writes [$];
	int unsigned       writes_planned;
	int unsigned       mismatches;
	bit                no_idle;
	int unsigned       quiet;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned eff_ext(cfg_t c, int d);
		int unsigned e;
		e = 32'(c.ext[d]);
		if (e == 0) return 1;
		if (e > DEF_MAX_EXTENT) return DEF_MAX_EXTENT;
		return e;
	endfunction

	function automatic longint unsigned padded_ext(cfg_t c, int d);
		return eff_ext(c, d) + c.pad_before[8*(3-d) +: 8] + c.pad_after[8*(3-d) +: 8];
	endfunction

	// product of padded extents, saturated at the index range
	function automatic longint unsigned padded_total(cfg_t c);
		longint unsigned cap;
		longint unsigned t;
		cap = 64'd1 << DEF_INDEX_BITS;
		t = padded_ext(c, 0);
		for (int d = 1; d < NUM_DIMS; d++) begin
			t = t * padded_ext(c, d);
			if (t > cap) t = cap;
		end
		return t;
	endfunction

	function automatic logic [FIELD_W-1:0] scatter_index(cfg_t c);
		longint unsigned idx;
		idx = coord[0] + c.pad_before[31:24];
		for (int d = 1; d < NUM_DIMS; d++)
			idx = idx * padded_ext(c, d) + coord[d] + c.pad_before[8*(3-d) +: 8];
		return idx[FIELD_W-1:0];
	endfunction

	function automatic void predict_write(logic f, logic [FIELD_W-1:0] v);
		longint unsigned     total;
		logic [NUM_DIMS-1:0] at_end;
		bit                  carry;
		pad_write_t          w;
		if (f == FUNC_FILL) begin
			total = padded_total(shape);
			if (fill_pos < total) begin
				w.index = fill_pos[FIELD_W-1:0];
				w.value = shape.pad_value;
				w.last = (fill_pos + 1 == total);
				pending_writes.push_back(w);
				fill_pos++;
				writes_planned++;
			end
		end else if (!data_finished) begin
			// a counter past a shrunken extent counts as at its end
			for (int d = 0; d < NUM_DIMS; d++)
				at_end[d] = (coord[d] + 1 >= eff_ext(shape, d));
			w.index = scatter_index(shape);
			w.value = v;
			w.last = &at_end;
			pending_writes.push_back(w);
			writes_planned++;
			carry = 1'b1;
			for (int d = NUM_DIMS - 1; d >= 0; d--) begin
				if (carry) begin
					if (at_end[d]) begin
						coord[d] = 0;
					end else begin
						coord[d]++;
						carry = 1'b0;
					end
				end
			end
			if (carry) data_finished = 1'b1;
		end
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] random_pads();
		logic [31:0] p;
		for (int d = 0; d < NUM_DIMS; d++)
			p[8*d +: 8] = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
		return p;
	endfunction

	task automatic send_req(input logic f, input logic [FIELD_W-1:0] v);
		int gap;
		@(negedge clk);
		if (!no_idle && $urandom_range(99) < 13) begin
			gap = ($urandom_range(9) == 0) ? $urandom_range(8, 2) : 1;
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.func <= f;
		item_ch.elem_value <= v;
		do @(posedge clk); while (!item_ch.ready);
		predict_write(f, v);
	endtask

	// drop the request, let every write come back, then let the pipe go quiet
	task automatic drain();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (pending_writes.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_IN_BATCHES:  shape.ext[0] = data[EXT_W-1:0];
			REG_IN_CHANNELS: shape.ext[1] = data[EXT_W-1:0];
			REG_IN_HEIGHT:   shape.ext[2] = data[EXT_W-1:0];
			REG_IN_WIDTH:    shape.ext[3] = data[EXT_W-1:0];
			REG_PAD_BEFORE:  shape.pad_before = data;
			REG_PAD_AFTER:   shape.pad_after = data;
			REG_PAD_VALUE:   shape.pad_value = data;
			default: ;
		endcase
	endtask

	task automatic load_shape(input logic [31:0] b, input logic [31:0] c, input logic [31:0] h,
			input logic [31:0] w, input logic [31:0] pb, input logic [31:0] pa,
			input logic [31:0] pv);
		drain();
		write_reg(REG_IN_BATCHES, b);
		write_reg(REG_IN_CHANNELS, c);
		write_reg(REG_IN_HEIGHT, h);
		write_reg(REG_IN_WIDTH, w);
		write_reg(REG_PAD_BEFORE, pb);
		write_reg(REG_PAD_AFTER, pa);
		write_reg(REG_PAD_VALUE, pv);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// a tensor with large batch extent, so the data stream keeps going
	task automatic data_round(input int n, input bit pause_mid);
		logic [31:0] b;
		logic [31:0] w;
		if (coord[0] + 100 < DEF_MAX_EXTENT && $urandom_range(4) != 0)
			b = $urandom_range(DEF_MAX_EXTENT, coord[0] + 100);
		else
			b = $urandom_range(2047, DEF_MAX_EXTENT);
		w = ($urandom_range(7) == 0) ? $urandom_range(2047, 1000) : $urandom_range(12, 1);
		load_shape(b, $urandom_range(4), $urandom_range(6), w, random_pads(), random_pads(),
			rand_word());
		for (int i = 0; i < n; i++) begin
			if (pause_mid && i == n / 2) drain();
			send_req(($urandom_range(99) < 80) ? FUNC_DATA : FUNC_FILL, rand_word());
		end
	endtask

	// pick a small tensor whose padded total lies just past the fill position
	task automatic fill_round();
		cfg_t            cand;
		cfg_t            best;
		longint unsigned t;
		longint unsigned best_t;
		int              sent;
		best_t = 0;
		best = shape;
		best.ext = {NUM_DIMS{11'd1024}};
		for (int k = 0; k < 4000; k++) begin
			cand = '0;
			for (int d = 0; d < NUM_DIMS; d++) begin
				cand.ext[d] = EXT_W'($urandom_range(6, 1));
				cand.pad_before[8*d +: 8] = PAD_W'($urandom_range(2));
				cand.pad_after[8*d +: 8] = PAD_W'($urandom_range(2));
			end
			t = padded_total(cand);
			if (t > fill_pos && (best_t == 0 || t < best_t)) begin
				best = cand;
				best_t = t;
			end
			if (best_t != 0 && best_t <= fill_pos + 48) break;
		end
		load_shape(32'(best.ext[0]), 32'(best.ext[1]), 32'(best.ext[2]), 32'(best.ext[3]),
			best.pad_before, best.pad_after, rand_word());
		sent = 0;
		while (fill_pos < padded_total(shape) && sent < 200) begin
			// the data stream is over: mix in ignored data requests
			if (data_finished && $urandom_range(9) == 0)
				send_req(FUNC_DATA, rand_word());
			else
				send_req(FUNC_FILL, rand_word());
			sent++;
		end
		repeat ($urandom_range(3, 1)) send_req(FUNC_FILL, rand_word());
	endtask

	task automatic test_reset_fill();
		// reset shape covers a single position; the second tick writes nothing
		send_req(FUNC_FILL, 32'h0000_0000);
		send_req(FUNC_FILL, 32'hFFFF_FFFF);
	endtask

	task automatic test_extreme_shapes();
		load_shape(32'd2047, 32'd0, 32'd2, 32'd3, 32'hFF00_0101, 32'h00FF_0102, 32'hFFFF_FFFF);
		send_req(FUNC_FILL, 32'h1234_5678);
		send_req(FUNC_DATA, 32'h0000_0000);
		send_req(FUNC_DATA, 32'hFFFF_FFFF);
		send_req(FUNC_DATA, 32'h0000_0001);
		send_req(FUNC_DATA, 32'h8000_0000);
		send_req(FUNC_FILL, 32'hFFFF_FFFF);
		send_req(FUNC_DATA, 32'hAAAA_AAAA);
		send_req(FUNC_DATA, 32'h5555_5555);
		send_req(FUNC_DATA, 32'h7FFF_FFFF);
		send_req(FUNC_DATA, $urandom);
		send_req(FUNC_FILL, 32'h0000_0000);
		// saturated total and wrapped indexes
		load_shape(32'd2047, 32'd1024, 32'd1025, 32'd2047, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'h0000_0000);
		send_req(FUNC_FILL, $urandom);
		send_req(FUNC_DATA, 32'hFFFF_FFFF);
		send_req(FUNC_DATA, 32'h0000_0000);
		send_req(FUNC_FILL, $urandom);
		send_req(FUNC_DATA, $urandom);
	endtask

	task automatic test_midstream_shrink();
		// column counter now sits past the new width and must wrap
		load_shape(32'd1024, 32'd1, 32'd1, 32'd1, 32'h0000_0000, 32'h0000_0000, 32'h5A5A_5A5A);
		send_req(FUNC_DATA, $urandom);
		send_req(FUNC_DATA, $urandom);
		send_req(FUNC_FILL, $urandom);
	endtask

	task automatic test_random_rounds();
		int rounds;
		rounds = 0;
		data_round(120, 1'b1);
		no_idle = 1'b1;
		data_round(150, 1'b0);
		no_idle = 1'b0;
		while (writes_planned < 950 && rounds < 40) begin
			if ($urandom_range(2) == 0)
				fill_round();
			else
				data_round($urandom_range(100, 40), $urandom_range(3) == 0);
			rounds++;
		end
	endtask

	task automatic test_data_end();
		int sent;
		load_shape(coord[0] + 1, $urandom_range(3, 1), $urandom_range(3, 1), $urandom_range(3, 1),
			random_pads(), random_pads(), rand_word());
		sent = 0;
		while (!data_finished && sent < 200) begin
			send_req(($urandom_range(99) < 15) ? FUNC_FILL : FUNC_DATA, rand_word());
			sent++;
		end
		// past the last element nothing more is written
		send_req(FUNC_DATA, rand_word());
		send_req(FUNC_DATA, rand_word());
		send_req(FUNC_FILL, rand_word());
		send_req(FUNC_DATA, rand_word());
	endtask

	always @(negedge clk) begin
		result_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 13);
	end

	always @(posedge clk) begin
		pad_write_t w;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_writes.size() == 0) begin
				$display("%0t: unexpected write index %h value %h last %b", $time,
					result_ch.out_index, result_ch.out_value, result_ch.phase_last);
				mismatches++;
			end else begin
				w = pending_writes.pop_front();
				if (result_ch.out_index !== w.index) begin
					$display("%0t: out_index expected %h actual %h", $time, w.index,
						result_ch.out_index);
					mismatches++;
				end
				if (result_ch.out_value !== w.value) begin
					$display("%0t: out_value expected %h actual %h", $time, w.value,
						result_ch.out_value);
					mismatches++;
				end
				if (result_ch.phase_last !== w.last) begin
					$display("%0t: phase_last expected %b actual %b", $time, w.last,
						result_ch.phase_last);
					mismatches++;
				end
			end
		end
	end

	// end the run when no request, write or register write moves for too long
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
			$display("FAIL tensor_constant_pad_scatter_unit");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.func = FUNC_FILL;
		item_ch.elem_value = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_IN_BATCHES;
		cfg_ch.data = '0;
		shape = '0;
		for (int d = 0; d < NUM_DIMS; d++) begin
			shape.ext[d] = 11'd1;
			coord[d] = 0;
		end
		fill_pos = 0;
		data_finished = 1'b0;
		writes_planned = 0;
		mismatches = 0;
		no_idle = 1'b0;
		quiet = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_fill();
		test_extreme_shapes();
		test_midstream_shrink();
		test_random_rounds();
		test_data_end();

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("PASS tensor_constant_pad_scatter_unit");
		else
			$display("FAIL tensor_constant_pad_scatter_unit");
		$finish;
	end

endmodule
